// ===== design/clcd_pkg.sv =====
// Shared types and constants for the character LCD bus write sequencer.
// No dependencies; all other design files but the checker import it.
package clcd_pkg;

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_DATA = 2'd1,
    REQ_POS  = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_FOUR_BIT_MODE  = 2'd0,
    CFG_PULSE_US_EIGHT = 2'd1,
    CFG_PULSE_US_FOUR  = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_e;

  localparam logic [7:0]  CMD_SET_DDRAM   = 8'h80;
  localparam logic [7:0]  ROW1_OFFSET     = 8'h40;
  localparam logic [15:0] PULSE_EIGHT_RST = 16'd2000;
  localparam logic [15:0] PULSE_FOUR_RST  = 16'd1000;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // One classified request: the byte to write and the RS level.
  typedef struct packed {
    logic       rs;
    logic [7:0] byte_val;
  } clcd_item_t;

  typedef struct packed {
    logic        nibble_mode;
    logic [15:0] pulse_eight;
    logic [15:0] pulse_four;
  } clcd_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } clcd_qstat_t;

endpackage

// ===== design/clcd_front.sv =====
// Front end: accepts requests, drops unused types and turns each request
// into a byte plus RS level held in a one-entry stage. Uses clcd_pkg.
module clcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          value_i,
  input  logic                row_i,
  input  logic [5:0]          column_i,
  input  clcd_pkg::clcd_qstat_t q_stat_i,
  output logic                push_o,
  output clcd_pkg::clcd_item_t push_item_o
);
  import clcd_pkg::*;

  logic       valid_q, valid_d;
  clcd_item_t item_q, item_d;
  logic       accept;
  logic       useful;

  assign push_o      = valid_q && !q_stat_i.full;
  assign in_stall_o  = valid_q && q_stat_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign useful      = (req_type_i != REQ_NONE);
  assign push_item_o = item_q;

  always_comb begin
    item_d = item_q;
    valid_d = valid_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept && useful) begin
      valid_d = 1'b1;
      case (req_type_i)
        REQ_CMD: begin
          item_d.rs       = 1'b0;
          item_d.byte_val = value_i;
        end
        REQ_DATA: begin
          item_d.rs       = 1'b1;
          item_d.byte_val = value_i;
        end
        REQ_POS: begin
          // Column is below 64, so the sum always fits in eight bits.
          item_d.rs       = 1'b0;
          item_d.byte_val = CMD_SET_DDRAM + (row_i ? ROW1_OFFSET : 8'h00)
                            + {2'b00, column_i};
        end
        default: begin
          item_d = item_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ===== design/clcd_queue.sv =====
// Small request queue between the front end and the bus sequencer.
// Uses clcd_pkg for the entry and status types.
module clcd_queue #(
  parameter int unsigned Depth = clcd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  clcd_pkg::clcd_item_t push_item_i,
  input  logic                 pop_i,
  output clcd_pkg::clcd_item_t head_o,
  output clcd_pkg::clcd_qstat_t stat_o
);
  import clcd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  clcd_item_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/clcd_back.sv =====
// Bus sequencer, uses clcd_pkg: each queued byte goes through its enable
// phases, one per cycle while not stalled, into a registered output.
module clcd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clcd_pkg::clcd_cfg_t   cfg_i,
  input  clcd_pkg::clcd_item_t  head_i,
  input  clcd_pkg::clcd_qstat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  reg_select_o,
  output logic                  read_write_o,
  output logic                  enable_o,
  output logic [7:0]            data_pins_o,
  output logic [15:0]           hold_us_o,
  output logic                  last_o
);
  import clcd_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  latch_q, latch_d;
  logic        valid_q, valid_d;
  logic        rs_q, en_q, last_q;
  logic [7:0]  pins_q;
  logic [15:0] hold_q;

  logic        advance, fire, is_last, en_now;
  logic [7:0]  pins_now;
  logic [15:0] hold_now;

  assign advance  = !valid_q || !out_stall_i;
  assign fire     = advance && !q_stat_i.empty;
  assign is_last  = cfg_i.nibble_mode ? (phase_q == 2'd3) : (phase_q == 2'd1);
  assign en_now   = !phase_q[0];
  // In four-bit mode only D7..D4 carry the nibble; D3..D0 keep the latch.
  assign pins_now = cfg_i.nibble_mode
                    ? {(phase_q[1] ? head_i.byte_val[3:0] : head_i.byte_val[7:4]),
                       latch_q[3:0]}
                    : head_i.byte_val;
  assign hold_now = en_now ? (cfg_i.nibble_mode ? cfg_i.pulse_four : cfg_i.pulse_eight)
                           : 16'd0;
  assign pop_o    = fire && is_last;

  always_comb begin
    phase_d = phase_q;
    latch_d = latch_q;
    valid_d = valid_q;
    if (advance) begin
      valid_d = fire;
    end
    if (fire) begin
      phase_d = is_last ? 2'd0 : phase_q + 2'd1;
      if (is_last) begin
        latch_d = pins_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      latch_q <= 8'h00;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      latch_q <= latch_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rs_q   <= head_i.rs;
      en_q   <= en_now;
      pins_q <= pins_now;
      hold_q <= hold_now;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign reg_select_o = rs_q;
  assign read_write_o = 1'b0;
  assign enable_o     = en_q;
  assign data_pins_o  = pins_q;
  assign hold_us_o    = hold_q;
  assign last_o       = last_q;

endmodule

// ===== design/char_lcd_bus_write_sequencer.sv =====
// Top level of the character LCD bus write sequencer: configuration
// registers plus front end, request queue and bus sequencer. Uses clcd_pkg.
//
// Usage: the request channel (in_valid_i / in_stall_o) takes a command byte,
// a data byte or a cursor position. Each request yields a series of bus
// phases on the phase channel (out_valid_o / out_stall_i): two phases in
// eight-bit mode (E high, E low) and four in four-bit mode (high nibble then
// low nibble, each E high then E low). last_o marks the final phase.
// Request type 3 is taken and produces no phases.
// A request passes the front-end stage, a queue entry and the output
// register before its first phase is valid. Throughput: the bus sequencer
// emits one phase per cycle while the receiver does not stall, so it holds
// each request for all its phases; the front end and queue take a new
// request every cycle until both the queue and the front-end stage are full.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready and
// should only be written while no request is in flight.
// Reset clears the queue and output valid, sets eight-bit mode, 2000 us and
// 1000 us pulse times, and zeroes the D7..D0 latch. When the receiver stalls,
// the current phase holds and the queue fills, then in_stall_o rises.
module char_lcd_bus_write_sequencer #(
  parameter int unsigned QueueDepth = clcd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  value_i,
  input  logic        row_i,
  input  logic [5:0]  column_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reg_select_o,
  output logic        read_write_o,
  output logic        enable_o,
  output logic [7:0]  data_pins_o,
  output logic [15:0] hold_us_o,
  output logic        last_o
);
  import clcd_pkg::*;

  clcd_cfg_t   cfg_q, cfg_d;
  clcd_qstat_t q_stat;
  clcd_item_t  push_item, head;
  logic        push, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FOUR_BIT_MODE:  cfg_d.nibble_mode = cfg_data_i[0];
        CFG_PULSE_US_EIGHT: cfg_d.pulse_eight = cfg_data_i;
        CFG_PULSE_US_FOUR:  cfg_d.pulse_four  = cfg_data_i;
        default:            cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nibble_mode <= 1'b0;
      cfg_q.pulse_eight <= PULSE_EIGHT_RST;
      cfg_q.pulse_four  <= PULSE_FOUR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  clcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  clcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  clcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reg_select_o (reg_select_o),
    .read_write_o (read_write_o),
    .enable_o     (enable_o),
    .data_pins_o  (data_pins_o),
    .hold_us_o    (hold_us_o),
    .last_o       (last_o)
  );

endmodule

// ===== design/clcd_checker.sv =====
// Port-level checks for the character LCD bus write sequencer, attached to
// the top level by the bind statement at the end. Standalone module.
module clcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        read_write_i,
  input logic        enable_i,
  input logic [15:0] hold_us_i,
  input logic        last_i
);

  // A held phase must stay offered until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("phase valid dropped while stalled");

  // An enable-low phase is a write and has no hold time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !enable_i |-> !read_write_i && hold_us_i == 16'd0)
    else $error("enable-low phase with nonzero hold or read");

  // An enable-high phase never ends a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && enable_i |-> !last_i)
    else $error("request ended on an enable-high phase");

  // After an enable-high transfer the matching enable-low phase follows at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && enable_i |=> out_valid_i && !enable_i)
    else $error("enable-low phase missing after enable-high transfer");

endmodule

bind char_lcd_bus_write_sequencer clcd_checker u_clcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_write_i (read_write_o),
  .enable_i     (enable_o),
  .hold_us_i    (hold_us_o),
  .last_i       (last_o)
);
